// File: rtl/dlpom_pkg.sv
// ----------------------------------------------------------------------------
// dlpom_pkg
// Shared widths, constants, register indexes and types of the low-pulse
// occupancy meter.
// ----------------------------------------------------------------------------
package dlpom_pkg;

    localparam int CNT_W  = 16;
    localparam int DIV_W  = 10;
    localparam int RAT_W  = 8;
    localparam int CONC_W = 31;
    localparam int CLS_W  = 3;
    localparam int IDX_W  = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SAMPLE = 2'd1;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 16'd31000;
    localparam logic [CNT_W-1:0] SAMPLE_RESET = 16'd30000;
    localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;

    // x / 100 for any 16-bit x equals (x * 83887) >> 23.
    localparam logic [16:0] DIV_RECIP = 17'd83887;
    localparam int          DIV_SHIFT = 23;

    localparam logic [6:0]  POLY_C3 = 7'd110;
    localparam logic [8:0]  POLY_C2 = 9'd380;
    localparam logic [15:0] POLY_C1 = 16'd52000;
    localparam logic [5:0]  POLY_C0 = 6'd62;

    localparam logic [CONC_W-1:0] TH_GOOD   = 31'd100000;
    localparam logic [CONC_W-1:0] TH_ACCEPT = 31'd1000000;
    localparam logic [CONC_W-1:0] TH_HEAVY  = 31'd2000000;
    localparam logic [CONC_W-1:0] TH_HAZARD = 31'd5000000;

    localparam logic [CLS_W-1:0] CLS_CLEAN  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_GOOD   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_ACCEPT = 3'd2;
    localparam logic [CLS_W-1:0] CLS_HEAVY  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_HAZARD = 3'd4;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/dlpom_queue.sv
// ----------------------------------------------------------------------------
// dlpom_queue
// Short queue of closed-window totals between the front and back parts.
// ----------------------------------------------------------------------------
module dlpom_queue
    import dlpom_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [CNT_W-1:0] i_push_data,
    input  logic             i_pop,
    output logic [CNT_W-1:0] o_head,
    output t_q_status        o_status
);

    logic [CNT_W-1:0] r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_AW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full || i_pop)
        else $error("Transaction pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("Pop from an empty queue.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("Queue count exceeds its depth.");

endmodule

// File: rtl/dlpom_front.sv
// ----------------------------------------------------------------------------
// dlpom_front
// Accepts tick transactions, tracks low pulses and the window, and pushes
// the window total into the queue when the window closes.
// ----------------------------------------------------------------------------
module dlpom_front
    import dlpom_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_sensor_low,
    input  logic [CNT_W-1:0] i_window_ticks,
    input  t_q_status        i_q_status,
    output logic             o_stall,
    output logic             o_push,
    output logic [CNT_W-1:0] o_push_data
);

    logic             r_prev_low;
    logic             r_in_pulse;
    logic [CNT_W-1:0] r_open;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_tick;

    logic             n_in_pulse;
    logic [CNT_W-1:0] n_open;
    logic [CNT_W-1:0] n_total;
    logic [CNT_W:0]   tick_inc;
    logic [CNT_W:0]   total_sum;
    logic             accept;
    logic             close;

    assign accept    = i_valid && !i_q_status.full;
    assign tick_inc  = {1'b0, r_tick} + 1'b1;
    assign close     = (tick_inc > {1'b0, i_window_ticks});
    assign total_sum = {1'b0, r_total} + {1'b0, r_open};

    always_comb begin
        n_in_pulse = r_in_pulse;
        n_open     = r_open;
        n_total    = r_total;
        if (i_sensor_low && !r_prev_low) begin
            n_in_pulse = 1'b1;
            n_open     = CNT_W'(1);
        end else if (i_sensor_low && r_in_pulse) begin
            n_open = (r_open == CNT_MAX) ? CNT_MAX : r_open + 1'b1;
        end else if (!i_sensor_low && r_prev_low && r_in_pulse) begin
            n_total    = total_sum[CNT_W] ? CNT_MAX : total_sum[CNT_W-1:0];
            n_in_pulse = 1'b0;
            n_open     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_low <= 1'b0;
            r_in_pulse <= 1'b0;
            r_open     <= '0;
            r_total    <= '0;
            r_tick     <= '0;
        end else if (accept) begin
            r_prev_low <= i_sensor_low;
            if (close) begin
                r_in_pulse <= 1'b0;
                r_open     <= '0;
                r_total    <= '0;
                r_tick     <= '0;
            end else begin
                r_in_pulse <= n_in_pulse;
                r_open     <= n_open;
                r_total    <= n_total;
                r_tick     <= tick_inc[CNT_W-1:0];
            end
        end
    end

    assign o_stall     = i_q_status.full;
    assign o_push      = accept && close;
    assign o_push_data = n_total;

endmodule

// File: rtl/dlpom_back.sv
// ----------------------------------------------------------------------------
// dlpom_back
// Turns a window total into ratio, concentration, air class and lamps,
// using a serial divider and a short multiply sequence, and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module dlpom_back
    import dlpom_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_sample_time_ms,
    input  t_q_status         i_q_status,
    input  logic [CNT_W-1:0]  i_q_head,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [CNT_W-1:0]  o_low_total_ms,
    output logic [RAT_W-1:0]  o_occupancy_ratio,
    output logic [CONC_W-1:0] o_concentration_centi,
    output logic [CLS_W-1:0]  o_air_class,
    output logic              o_lamp_green,
    output logic              o_lamp_orange,
    output logic              o_lamp_red
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_DIVIDE,
        S_SQUARE,
        S_CUBE,
        S_POLY,
        S_CLASS
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_total;
    logic [DIV_W-1:0]    r_div;
    logic [DIV_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_quo;
    logic [3:0]          r_step;
    logic [RAT_W-1:0]    r_ratio;
    logic [15:0]         r_r2;
    logic [23:0]         r_r3;
    logic [23:0]         r_lin;
    logic [CONC_W-1:0]   r_conc;

    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_total;
    logic [RAT_W-1:0]    r_out_ratio;
    logic [CONC_W-1:0]   r_out_conc;
    logic [CLS_W-1:0]    r_out_class;

    logic [32:0]         scale_prod;
    logic [DIV_W-1:0]    scale_div;
    logic [DIV_W:0]      rem_sh;
    logic                rem_ge;
    logic [31:0]         poly_sum;
    logic [CLS_W-1:0]    cls;
    logic                out_free;

    assign scale_prod = 33'(i_sample_time_ms) * 33'(DIV_RECIP);
    assign scale_div  = scale_prod[DIV_SHIFT +: DIV_W];
    assign rem_sh     = {r_rem, r_quo[CNT_W-1]};
    assign rem_ge     = (rem_sh >= {1'b0, r_div});
    assign poly_sum   = 32'(r_r3) * 32'(POLY_C3) + 32'(r_lin) - 32'(r_r2) * 32'(POLY_C2);
    assign out_free   = !r_out_valid || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_q_status.empty;

    always_comb begin
        if (r_conc < TH_GOOD) begin
            cls = CLS_CLEAN;
        end else if (r_conc < TH_ACCEPT) begin
            cls = CLS_GOOD;
        end else if (r_conc < TH_HEAVY) begin
            cls = CLS_ACCEPT;
        end else if (r_conc < TH_HAZARD) begin
            cls = CLS_HEAVY;
        end else begin
            cls = CLS_HAZARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CLASS && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_total <= i_q_head;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_div   <= (scale_div == '0) ? DIV_W'(1) : scale_div;
                    r_rem   <= '0;
                    r_quo   <= r_total;
                    r_step  <= '0;
                    r_state <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    if (rem_ge) begin
                        r_rem <= DIV_W'(rem_sh - {1'b0, r_div});
                    end else begin
                        r_rem <= rem_sh[DIV_W-1:0];
                    end
                    r_quo  <= {r_quo[CNT_W-2:0], rem_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_ratio <= (r_quo[CNT_W-1:RAT_W] != '0) ? '1 : r_quo[RAT_W-1:0];
                    r_state <= S_CUBE;
                end
                S_CUBE: begin
                    r_r2    <= 16'(r_ratio) * 16'(r_ratio);
                    r_lin   <= 24'(r_ratio) * 24'(POLY_C1) + 24'(POLY_C0);
                    r_state <= S_POLY;
                end
                S_POLY: begin
                    if (r_step == 4'd0) begin
                        r_r3    <= 24'(r_r2) * 24'(r_ratio);
                        r_step  <= 4'd1;
                    end else begin
                        r_conc  <= poly_sum[CONC_W-1:0];
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (out_free) begin
                        r_out_total <= r_total;
                        r_out_ratio <= r_ratio;
                        r_out_conc  <= r_conc;
                        r_out_class <= cls;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid               = r_out_valid;
    assign o_low_total_ms        = r_out_total;
    assign o_occupancy_ratio     = r_out_ratio;
    assign o_concentration_centi = r_out_conc;
    assign o_air_class           = r_out_class;
    assign o_lamp_green          = (r_out_class == CLS_CLEAN) || (r_out_class == CLS_GOOD);
    assign o_lamp_orange         = (r_out_class == CLS_GOOD) || (r_out_class == CLS_ACCEPT)
                                   || (r_out_class == CLS_HEAVY);
    assign o_lamp_red            = (r_out_class == CLS_HEAVY) || (r_out_class == CLS_HAZARD);

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) |-> (r_div != '0))
        else $error("Divider started with a zero divisor.");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_air_class <= CLS_HAZARD))
        else $error("Air class out of range.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_concentration_centi)))
        else $error("Stalled result transaction was overwritten.");

endmodule

// File: rtl/dust_low_pulse_occupancy_meter.sv
// ----------------------------------------------------------------------------
// dust_low_pulse_occupancy_meter
// Low-pulse occupancy meter for a particulate sensor with a ratio, a cubic
// concentration curve, an air class and three lamp bits per window.
//
// Input channel: one transaction per millisecond tick carrying the sampled
// sensor level (i_valid / o_stall). The front part takes one tick per cycle
// while the two-entry result queue has room.
// Output channel: one transaction per closed window (o_valid / i_stall),
// held in an output register until taken.
// From the closing tick, the result passes the 16-step bit-serial divider plus
// scaling, squaring, cubing, polynomial and class steps before o_valid. The back
// part takes the next window only when idle, so windows that close faster than
// it finishes them fill the queue and then raise o_stall.
// When the receiver stalls, the result register holds; the back part waits,
// then the queue fills, then the input stalls.
// Reset clears the window, pulse and queue state and loads window_ticks
// with 31000 and sample_time_ms with 30000. Configuration writes take
// effect at once and are meant for an idle block.
// ----------------------------------------------------------------------------
module dust_low_pulse_occupancy_meter
    import dlpom_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_sensor_low,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CNT_W-1:0]  o_low_total_ms,
    output logic [RAT_W-1:0]  o_occupancy_ratio,
    output logic [CONC_W-1:0] o_concentration_centi,
    output logic [CLS_W-1:0]  o_air_class,
    output logic              o_lamp_green,
    output logic              o_lamp_orange,
    output logic              o_lamp_red
);

    logic [CNT_W-1:0] r_window_ticks;
    logic [CNT_W-1:0] r_sample_time_ms;

    t_q_status        q_status;
    logic             q_push;
    logic             q_pop;
    logic [CNT_W-1:0] q_push_data;
    logic [CNT_W-1:0] q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks   <= WINDOW_RESET;
            r_sample_time_ms <= SAMPLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW: r_window_ticks   <= i_cfg_data;
                CFG_SAMPLE: r_sample_time_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dlpom_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_sensor_low   (i_sensor_low),
        .i_window_ticks (r_window_ticks),
        .i_q_status     (q_status),
        .o_stall        (o_stall),
        .o_push         (q_push),
        .o_push_data    (q_push_data)
    );

    dlpom_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    dlpom_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_sample_time_ms      (r_sample_time_ms),
        .i_q_status            (q_status),
        .i_q_head              (q_head),
        .o_pop                 (q_pop),
        .i_stall               (i_stall),
        .o_valid               (o_valid),
        .o_low_total_ms        (o_low_total_ms),
        .o_occupancy_ratio     (o_occupancy_ratio),
        .o_concentration_centi (o_concentration_centi),
        .o_air_class           (o_air_class),
        .o_lamp_green          (o_lamp_green),
        .o_lamp_orange         (o_lamp_orange),
        .o_lamp_red            (o_lamp_red)
    );

endmodule
